[src/lec_pkg.sv]
// ----------------------------------------------------------------------------
// LT symbol encoder package
// Shared constants, beat types, sequencer states and remainder unit bundles.
// ----------------------------------------------------------------------------
package lec_pkg;

	localparam int MAX_SYMBOLS  = 1024;
	localparam int SYMBOL_WORDS = 8;
	localparam int IDX_W        = $clog2(MAX_SYMBOLS);
	localparam int WIDX_W       = $clog2(SYMBOL_WORDS);
	localparam int SADDR_W      = IDX_W + WIDX_W;
	localparam int MOD_W        = 12;

	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_XOR  = 2'd1;
	localparam logic [1:0] MODE_SWAP = 2'd2;
	localparam logic [1:0] MODE_ENC  = 2'd3;

	localparam logic REG_SYMBOL_COUNT  = 1'b0;
	localparam logic REG_PRIME_MODULUS = 1'b1;

	typedef struct packed {
		logic [1:0]  mode;
		logic [9:0]  target_index;
		logic [9:0]  other_index;
		logic [2:0]  word_index;
		logic [63:0] load_data;
		logic [10:0] degree;
		logic [10:0] step;
		logic [10:0] start_req;
	} cmd_t;

	typedef struct packed {
		logic [63:0] word;
		logic [2:0]  word_number;
		logic        last;
	} result_t;

	typedef struct packed {
		logic             start;
		logic [MOD_W-1:0] dividend;
		logic [MOD_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic             done;
		logic [MOD_W-1:0] remainder;
	} mod_rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_XWORDS,
		ST_XTAIL,
		ST_SWAP1,
		ST_SWAP2,
		ST_EAMOD,
		ST_SKIP,
		ST_STEP,
		ST_STEPW,
		ST_LRED,
		ST_MAPRD,
		ST_WORDS,
		ST_WTAIL,
		ST_OUT
	} state_t;

endpackage

[src/lec_mod_unit.sv]
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring remainder, one dividend bit per cycle, done pulses with the result.
// ----------------------------------------------------------------------------
module lec_mod_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  lec_pkg::mod_req_t req,
	output lec_pkg::mod_rsp_t rsp
);
	import lec_pkg::*;

	logic [MOD_W-1:0]         rem_q;
	logic [MOD_W-1:0]         dvd_q;
	logic [MOD_W-1:0]         div_q;
	logic [$clog2(MOD_W)-1:0] cnt_q;
	logic                     act_q;
	logic                     done_q;
	logic [MOD_W:0]           trial;
	logic [MOD_W:0]           rem_next;

	assign trial    = {rem_q, dvd_q[MOD_W-1]};
	assign rem_next = (trial >= {1'b0, div_q}) ? trial - {1'b0, div_q} : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= act_q && !req.start && (cnt_q == $clog2(MOD_W)'(MOD_W - 1));
			if (req.start) begin
				act_q <= 1'b1;
				cnt_q <= '0;
			end else if (act_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == $clog2(MOD_W)'(MOD_W - 1)) begin
					act_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			div_q <= req.divisor;
		end else if (act_q) begin
			rem_q <= rem_next[MOD_W-1:0];
			dvd_q <= {dvd_q[MOD_W-2:0], 1'b0};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.remainder = rem_q;

endmodule

[src/lec_sym_ram.sv]
// ----------------------------------------------------------------------------
// Symbol store
// Word memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module lec_sym_ram (
	input  logic                        clk,
	input  logic                        we,
	input  logic [lec_pkg::SADDR_W-1:0] waddr,
	input  logic [63:0]                 wdata,
	input  logic                        re,
	input  logic [lec_pkg::SADDR_W-1:0] raddr_a,
	input  logic [lec_pkg::SADDR_W-1:0] raddr_b,
	output logic [63:0]                 rdata_a,
	output logic [63:0]                 rdata_b
);
	import lec_pkg::*;

	logic [63:0] mem [MAX_SYMBOLS*SYMBOL_WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

[src/lec_map_ram.sv]
// ----------------------------------------------------------------------------
// Index map
// Logical to physical slot map with one write port and two registered reads.
// ----------------------------------------------------------------------------
module lec_map_ram (
	input  logic                      clk,
	input  logic                      we,
	input  logic [lec_pkg::IDX_W-1:0] waddr,
	input  logic [lec_pkg::IDX_W-1:0] wdata,
	input  logic                      re,
	input  logic [lec_pkg::IDX_W-1:0] raddr_a,
	input  logic [lec_pkg::IDX_W-1:0] raddr_b,
	output logic [lec_pkg::IDX_W-1:0] rdata_a,
	output logic [lec_pkg::IDX_W-1:0] rdata_b
);
	import lec_pkg::*;

	logic [IDX_W-1:0] mem [MAX_SYMBOLS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

[src/raptor_lt_symbol_encoder_unit.sv]
// ----------------------------------------------------------------------------
// LT symbol encoder
// Symbol store with index map, elimination replay and LT encoding sequencer.
// ----------------------------------------------------------------------------
// After reset the block clears the symbol store and rebuilds the identity map
// in one pass over the store, with busy high. A load looks up the map and then
// writes one store word, a swap writes both map entries in turn, and an xor
// reads and rewrites one store word per cycle. The length of an encode grows
// with the number of symbols combined, the indices skipped at or above the
// symbol count and the steps and skips whose index needs a full remainder,
// plus 8 result beats; the shared remainder unit and the single store read per
// word set that cost. Results come out as 8 beats on consecutive cycles and
// the receiver cannot stall them.
module raptor_lt_symbol_encoder_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  lec_pkg::cmd_t    cmd,
	output logic             result_valid,
	output lec_pkg::result_t result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import lec_pkg::*;

	state_t state_q, state_d;
	cmd_t   cmd_q;

	logic [10:0]        l_q;
	logic [11:0]        lp_q;
	logic [SADDR_W-1:0] clr_q;
	logic [WIDX_W-1:0]  wc_q, rd_w_q, oc_q;
	logic               rd_v_q, xw_v_q, first_q;
	logic [63:0]        acc_q [SYMBOL_WORDS];
	logic [IDX_W:0]     lim_q;
	logic [11:0]        p_q, am_q, b_q, n_q;
	logic [IDX_W-1:0]   k_q, extra_q;

	logic accept, cfg_we, skip_go, skip_giveup, step_fast;
	logic [12:0] step_sum, red_sum;
	logic [11:0] step_next, red_next, p_new;
	logic [IDX_W:0] lim_new;
	logic [10:0] d_new, dm1;
	logic wc_last, oc_last, clr_last;

	mod_req_t mreq;
	mod_rsp_t mrsp;

	logic               s_we, s_re, m_we, m_re;
	logic [SADDR_W-1:0] s_waddr, s_ra, s_rb;
	logic [63:0]        s_wdata, s_da, s_db;
	logic [IDX_W-1:0]   m_waddr, m_wdata, m_ra, m_rb, m_da, m_db;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_PRIME_MODULUS) ? {20'd0, lp_q} : {21'd0, l_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l_q  <= 11'd1024;
			lp_q <= 12'd1031;
		end else if (cfg_we) begin
			if (paddr[2] == REG_SYMBOL_COUNT) begin
				l_q <= pwdata[10:0];
			end else begin
				lp_q <= pwdata[11:0];
			end
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign wc_last  = (wc_q == WIDX_W'(SYMBOL_WORDS - 1));
	assign oc_last  = (oc_q == WIDX_W'(SYMBOL_WORDS - 1));
	assign clr_last = (clr_q == SADDR_W'(MAX_SYMBOLS*SYMBOL_WORDS - 1));

	assign skip_go     = ({1'b0, b_q} >= {1'b0, lim_q}) && (n_q < p_q);
	assign skip_giveup = ({1'b0, b_q} >= {1'b0, lim_q}) && !(n_q < p_q);
	assign step_fast   = (b_q < p_q);
	assign step_sum    = {1'b0, b_q} + {1'b0, am_q};
	assign step_next   = (step_sum >= {1'b0, p_q}) ? 12'(step_sum - {1'b0, p_q})
		: step_sum[11:0];
	assign red_sum     = {1'b0, mrsp.remainder} + {1'b0, am_q};
	assign red_next    = (red_sum >= {1'b0, p_q}) ? 12'(red_sum - {1'b0, p_q})
		: red_sum[11:0];

	assign p_new   = (lp_q == 12'd0) ? 12'd1 : lp_q;
	assign lim_new = (l_q == 11'd0) ? (IDX_W+1)'(1)
		: ((l_q > 11'(MAX_SYMBOLS)) ? (IDX_W+1)'(MAX_SYMBOLS) : (IDX_W+1)'(l_q));
	assign d_new   = (cmd.degree == 11'd0) ? 11'd1 : cmd.degree;
	assign dm1     = d_new - 11'd1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (clr_last) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd.mode)
						MODE_LOAD: state_d = ST_LOAD;
						MODE_XOR:  state_d = ST_XWORDS;
						MODE_SWAP: state_d = ST_SWAP1;
						MODE_ENC:  state_d = ST_EAMOD;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOAD:   state_d = ST_IDLE;
			ST_XWORDS: if (wc_last) state_d = ST_XTAIL;
			ST_XTAIL:  state_d = ST_IDLE;
			ST_SWAP1:  state_d = ST_SWAP2;
			ST_SWAP2:  state_d = ST_IDLE;
			ST_EAMOD:  if (mrsp.done) state_d = ST_SKIP;
			ST_SKIP: begin
				if (skip_go) state_d = ST_STEP;
				else if (skip_giveup) state_d = ST_LRED;
				else state_d = ST_MAPRD;
			end
			ST_STEP:   state_d = step_fast ? ST_SKIP : ST_STEPW;
			ST_STEPW:  if (mrsp.done) state_d = ST_SKIP;
			ST_LRED:   if (mrsp.done) state_d = ST_MAPRD;
			ST_MAPRD:  state_d = ST_WORDS;
			ST_WORDS:  if (wc_last) state_d = ST_WTAIL;
			ST_WTAIL:  state_d = (k_q < extra_q) ? ST_STEP : ST_OUT;
			ST_OUT:    if (oc_last) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mreq.start    = 1'b0;
		mreq.dividend = b_q;
		mreq.divisor  = p_q;
		m_re    = 1'b0;
		m_ra    = cmd.target_index;
		m_rb    = cmd.other_index;
		m_we    = 1'b0;
		m_waddr = cmd_q.target_index;
		m_wdata = m_db;
		s_re    = 1'b0;
		s_ra    = {m_db, wc_q};
		s_rb    = {m_da, wc_q};
		s_we    = 1'b0;
		s_waddr = {m_da, rd_w_q};
		s_wdata = s_da ^ s_db;
		unique case (state_q)
			ST_CLEAR: begin
				s_we    = 1'b1;
				s_waddr = clr_q;
				s_wdata = '0;
				m_we    = (clr_q[SADDR_W-1:IDX_W] == '0);
				m_waddr = clr_q[IDX_W-1:0];
				m_wdata = clr_q[IDX_W-1:0];
			end
			ST_IDLE: begin
				m_re          = accept;
				mreq.start    = accept && (cmd.mode == MODE_ENC);
				mreq.dividend = {1'b0, cmd.step};
				mreq.divisor  = p_new;
			end
			ST_LOAD: begin
				s_we    = 1'b1;
				s_waddr = {m_da, cmd_q.word_index};
				s_wdata = cmd_q.load_data;
			end
			ST_XWORDS: begin
				s_re = 1'b1;
			end
			ST_SWAP1: begin
				m_we = 1'b1;
			end
			ST_SWAP2: begin
				m_we    = 1'b1;
				m_waddr = cmd_q.other_index;
				m_wdata = m_da;
			end
			ST_SKIP: begin
				mreq.start   = skip_giveup;
				mreq.divisor = 12'(lim_q);
			end
			ST_STEP: begin
				mreq.start = !step_fast;
			end
			ST_MAPRD: begin
				m_re = 1'b1;
				m_ra = b_q[IDX_W-1:0];
			end
			ST_WORDS: begin
				s_re = 1'b1;
				s_ra = {m_da, wc_q};
			end
			default: begin
			end
		endcase
		if (xw_v_q) begin
			s_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			wc_q    <= '0;
			oc_q    <= '0;
			rd_v_q  <= 1'b0;
			xw_v_q  <= 1'b0;
			first_q <= 1'b0;
			k_q     <= '0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			rd_v_q  <= (state_q == ST_WORDS);
			xw_v_q  <= (state_q == ST_XWORDS);
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_WORDS || state_q == ST_XWORDS) begin
				wc_q <= wc_last ? '0 : wc_q + 1'b1;
			end
			if (state_q == ST_OUT) begin
				oc_q <= oc_last ? '0 : oc_q + 1'b1;
			end
			if (accept) begin
				wc_q    <= '0;
				oc_q    <= '0;
				k_q     <= '0;
				n_q     <= '0;
				first_q <= 1'b1;
			end
			if (state_q == ST_SKIP && skip_go) begin
				n_q <= n_q + 1'b1;
			end
			if (state_q == ST_WTAIL) begin
				first_q <= 1'b0;
				k_q     <= k_q + 1'b1;
				n_q     <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_w_q <= wc_q;
		if (accept) begin
			cmd_q   <= cmd;
			lim_q   <= lim_new;
			p_q     <= p_new;
			b_q     <= {1'b0, cmd.start_req};
			extra_q <= (dm1 > 11'(lim_new - 1'b1)) ? IDX_W'(lim_new - 1'b1)
				: IDX_W'(dm1);
		end
		if (state_q == ST_EAMOD && mrsp.done) begin
			am_q <= mrsp.remainder;
		end
		if (state_q == ST_STEP && step_fast) begin
			b_q <= step_next;
		end
		if (state_q == ST_STEPW && mrsp.done) begin
			b_q <= red_next;
		end
		if (state_q == ST_LRED && mrsp.done) begin
			b_q <= mrsp.remainder;
		end
		if (rd_v_q) begin
			acc_q[rd_w_q] <= first_q ? s_da : (acc_q[rd_w_q] ^ s_da);
		end
	end

	lec_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	lec_sym_ram u_store (
		.clk     (clk),
		.we      (s_we),
		.waddr   (s_waddr),
		.wdata   (s_wdata),
		.re      (s_re),
		.raddr_a (s_ra),
		.raddr_b (s_rb),
		.rdata_a (s_da),
		.rdata_b (s_db)
	);

	lec_map_ram u_map (
		.clk     (clk),
		.we      (m_we),
		.waddr   (m_waddr),
		.wdata   (m_wdata),
		.re      (m_re),
		.raddr_a (m_ra),
		.raddr_b (m_rb),
		.rdata_a (m_da),
		.rdata_b (m_db)
	);

	assign result_valid       = (state_q == ST_OUT);
	assign result.word        = acc_q[oc_q];
	assign result.word_number = 3'(oc_q);
	assign result.last        = result_valid && oc_last;

	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result beat while idle");

	a_first_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> (result.word_number == 3'd0))
		else $error("encoding symbol does not open with word zero");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted beat did not make the block busy");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result.last |=> !result_valid)
		else $error("result beat after the last word");

endmodule
